// ===== rtl/ptc_pkg.sv =====
`default_nettype none
package ptc_pkg;

   localparam logic [63:0] OFFSET_T    = 64'd128000;
   localparam logic [63:0] PRESS_FULL  = 64'd1048576;
   localparam logic [63:0] PRESS_SCALE = 64'd3125;
   localparam logic [63:0] ONE_Q47     = 64'h0000_8000_0000_0000;
   localparam logic [31:0] CENTI_MUL   = 32'd5;
   localparam logic [31:0] CENTI_RND   = 32'd128;
   localparam int unsigned DIV_STEPS   = 64;
   localparam int unsigned ADDR_W      = 5;
   localparam int unsigned DATA_W      = 64;

   typedef enum logic [1:0] {
      CSR_TEMP = 2'd0,
      CSR_PLOW = 2'd1,
      CSR_PMID = 2'd2,
      CSR_P9   = 2'd3
   } csr_idx_type;

   typedef struct packed {
      logic [15:0] t1;
      logic [15:0] t2;
      logic [15:0] t3;
      logic [15:0] p1;
      logic [15:0] p2;
      logic [15:0] p3;
      logic [15:0] p4;
      logic [15:0] p5;
      logic [15:0] p6;
      logic [15:0] p7;
      logic [15:0] p8;
      logic [15:0] p9;
   } cal_type;

   // one step of the divider chain
   typedef struct packed {
      logic [63:0] rem;
      logic [63:0] dq;
      logic [63:0] dvs;
      logic [31:0] tf;
      logic [31:0] tc;
      logic        neg;
      logic        dz;
   } div_type;

   typedef struct packed {
      logic [31:0] tf;
      logic [31:0] tc;
      logic [31:0] press;
      logic        dz;
   } rsp_type;

   function automatic logic [63:0] sx64(input logic [15:0] h);
      return {{48{h[15]}}, h};
   endfunction

   function automatic logic [31:0] sx32(input logic [15:0] h);
      return {{16{h[15]}}, h};
   endfunction

endpackage
`default_nettype wire

// ===== rtl/ptc_csr.sv =====
`default_nettype none
module ptc_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [ptc_pkg::ADDR_W-1:0]       paddr,
   input  logic [ptc_pkg::DATA_W-1:0]       pwdata,
   output logic [ptc_pkg::DATA_W-1:0]       prdata,
   output logic                             pready,
   output ptc_pkg::cal_type                 cal
);
   logic [47:0] temp_ff;
   logic [63:0] plow_ff;
   logic [63:0] pmid_ff;
   logic [15:0] p9_ff;
   logic        wr;
   ptc_pkg::csr_idx_type idx;

   assign pready = 1'b1;
   assign wr     = psel & penable & pwrite;
   assign idx    = ptc_pkg::csr_idx_type'(paddr[4:3]);

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_ff <= '0;
         plow_ff <= '0;
         pmid_ff <= '0;
         p9_ff   <= '0;
      end else if (wr) begin
         case (idx)
            ptc_pkg::CSR_TEMP: temp_ff <= pwdata[47:0];
            ptc_pkg::CSR_PLOW: plow_ff <= pwdata;
            ptc_pkg::CSR_PMID: pmid_ff <= pwdata;
            ptc_pkg::CSR_P9:   p9_ff   <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (idx)
         ptc_pkg::CSR_TEMP: prdata = {16'd0, temp_ff};
         ptc_pkg::CSR_PLOW: prdata = plow_ff;
         ptc_pkg::CSR_PMID: prdata = pmid_ff;
         ptc_pkg::CSR_P9:   prdata = {48'd0, p9_ff};
         default:           prdata = '0;
      endcase
   end

   assign cal.t1 = temp_ff[15:0];
   assign cal.t2 = temp_ff[31:16];
   assign cal.t3 = temp_ff[47:32];
   assign cal.p1 = plow_ff[15:0];
   assign cal.p2 = plow_ff[31:16];
   assign cal.p3 = plow_ff[47:32];
   assign cal.p4 = plow_ff[63:48];
   assign cal.p5 = pmid_ff[15:0];
   assign cal.p6 = pmid_ff[31:16];
   assign cal.p7 = pmid_ff[47:32];
   assign cal.p8 = pmid_ff[63:48];
   assign cal.p9 = p9_ff;

endmodule
`default_nettype wire

// ===== rtl/ptc_mul64.sv =====
`default_nettype none
// low 64 bits of 64x64 products, two stages: 32x32 partials, then sum
module ptc_mul64 #(
   parameter int unsigned LANES  = 1,
   parameter int unsigned SIDE_W = 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_vld,
   input  logic [LANES-1:0][63:0]      in_x,
   input  logic [LANES-1:0][63:0]      in_y,
   input  logic [SIDE_W-1:0]           in_side,
   output logic                        out_vld,
   output logic [LANES-1:0][63:0]      out_p,
   output logic [SIDE_W-1:0]           out_side
);
   logic                   vld_ff;
   logic [LANES-1:0][63:0] lo_ff;
   logic [LANES-1:0][31:0] cr_ff;
   logic [SIDE_W-1:0]      side_ff;
   logic                   out_vld_ff;
   logic [LANES-1:0][63:0] p_ff;
   logic [SIDE_W-1:0]      oside_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= 1'b0;
         out_vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff     <= in_vld;
         out_vld_ff <= vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int l = 0; l < LANES; l++) begin
            lo_ff[l] <= {32'd0, in_x[l][31:0]} * {32'd0, in_y[l][31:0]};
            cr_ff[l] <= in_x[l][31:0] * in_y[l][63:32] + in_x[l][63:32] * in_y[l][31:0];
            p_ff[l]  <= lo_ff[l] + {cr_ff[l], 32'd0};
         end
         side_ff  <= in_side;
         oside_ff <= side_ff;
      end
   end

   assign out_vld  = out_vld_ff;
   assign out_p    = p_ff;
   assign out_side = oside_ff;

endmodule
`default_nettype wire

// ===== rtl/ptc_div_cell.sv =====
`default_nettype none
// one restoring step of the unsigned 64-bit divide
module ptc_div_cell (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_vld,
   input  ptc_pkg::div_type in_d,
   output logic             out_vld,
   output ptc_pkg::div_type out_d
);
   logic             vld_ff;
   ptc_pkg::div_type d_ff;
   ptc_pkg::div_type d_in;
   logic [64:0]      sh;
   logic [64:0]      diff;
   logic             ge;

   assign sh   = {in_d.rem, in_d.dq[63]};
   assign diff = sh - {1'b0, in_d.dvs};
   assign ge   = ~diff[64];

   always_comb begin
      d_in     = in_d;
      d_in.rem = ge ? diff[63:0] : sh[63:0];
      d_in.dq  = {in_d.dq[62:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= 1'b0;
      else if (en) vld_ff <= in_vld;
   end

   always_ff @(posedge clock) begin
      if (en) d_ff <= d_in;
   end

   assign out_vld = vld_ff;
   assign out_d   = d_ff;

endmodule
`default_nettype wire

// ===== rtl/ptc_front.sv =====
`default_nettype none
// temperature path and pressure terms up to the divider operands
module ptc_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  ptc_pkg::cal_type cal,
   input  logic             in_vld,
   input  logic [19:0]      adc_temp,
   input  logic [19:0]      adc_press,
   output logic             out_vld,
   output ptc_pkg::div_type out_d
);
   typedef struct packed {
      logic [31:0] tf;
      logic [31:0] tc;
      logic [19:0] ap;
   } m1_side_type;

   typedef struct packed {
      logic [31:0] tf;
      logic [31:0] tc;
      logic [19:0] ap;
      logic [63:0] ap5;
      logic [63:0] ap2;
   } m2_side_type;

   typedef struct packed {
      logic [31:0] tf;
      logic [31:0] tc;
      logic [19:0] ap;
      logic [63:0] b;
   } m3_side_type;

   typedef struct packed {
      logic [31:0] tf;
      logic [31:0] tc;
      logic [63:0] den;
   } m4_side_type;

   logic        s1_vld_ff, s2_vld_ff, s3_vld_ff, s4_vld_ff;
   logic [31:0] s1_m1_ff, s1_m2_ff, s2_v1_ff, s2_m3_ff, s3_tf_ff;
   logic [31:0] s4_tf_ff, s4_tc_ff;
   logic [63:0] s4_a_ff;
   logic [19:0] s1_ap_ff, s2_ap_ff, s3_ap_ff, s4_ap_ff;
   logic [31:0] d1, d2, tf5;

   logic                  m1_vld, m2_vld, m3_vld, m4_vld;
   logic [2:0][63:0]      m1_p;
   logic [1:0][63:0]      m2_p;
   logic [0:0][63:0]      m3_p, m4_p;
   m1_side_type           m1_si, m1_so;
   m2_side_type           m2_si, m2_so;
   m3_side_type           m3_si, m3_so;
   m4_side_type           m4_si, m4_so;

   logic        r5_vld_ff, r6_vld_ff, r7_vld_ff;
   logic [31:0] r5_tf_ff, r5_tc_ff, r6_tf_ff, r6_tc_ff;
   logic [19:0] r5_ap_ff;
   logic [63:0] r5_b_ff, r5_s_ff, r6_den_ff, r6_x_ff;
   ptc_pkg::div_type r7_ff;
   logic [63:0] n;

   assign d1  = 32'(adc_temp[19:3]) - {15'd0, cal.t1, 1'b0};
   assign d2  = 32'(adc_temp[19:4]) - {16'd0, cal.t1};
   assign tf5 = s3_tf_ff * ptc_pkg::CENTI_MUL + ptc_pkg::CENTI_RND;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
         r5_vld_ff <= 1'b0;
         r6_vld_ff <= 1'b0;
         r7_vld_ff <= 1'b0;
      end else if (en) begin
         s1_vld_ff <= in_vld;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
         s4_vld_ff <= s3_vld_ff;
         r5_vld_ff <= m2_vld;
         r6_vld_ff <= m3_vld;
         r7_vld_ff <= m4_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_m1_ff <= d1 * ptc_pkg::sx32(cal.t2);
         s1_m2_ff <= d2 * d2;
         s1_ap_ff <= adc_press;
         s2_v1_ff <= 32'($signed(s1_m1_ff) >>> 11);
         s2_m3_ff <= 32'($signed(s1_m2_ff) >>> 12) * ptc_pkg::sx32(cal.t3);
         s2_ap_ff <= s1_ap_ff;
         s3_tf_ff <= s2_v1_ff + 32'($signed(s2_m3_ff) >>> 14);
         s3_ap_ff <= s2_ap_ff;
         s4_tf_ff <= s3_tf_ff;
         s4_tc_ff <= 32'($signed(tf5) >>> 8);
         s4_a_ff  <= {{32{s3_tf_ff[31]}}, s3_tf_ff} - ptc_pkg::OFFSET_T;
         s4_ap_ff <= s3_ap_ff;
      end
   end

   assign m1_si = '{tf: s4_tf_ff, tc: s4_tc_ff, ap: s4_ap_ff};

   // lanes: a*a, a*P5, a*P2
   ptc_mul64 #(.LANES(3), .SIDE_W($bits(m1_side_type))) u_m1 (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_vld   (s4_vld_ff),
      .in_x     ({s4_a_ff, s4_a_ff, s4_a_ff}),
      .in_y     ({s4_a_ff, ptc_pkg::sx64(cal.p5), ptc_pkg::sx64(cal.p2)}),
      .in_side  (m1_si),
      .out_vld  (m1_vld),
      .out_p    (m1_p),
      .out_side (m1_so)
   );

   assign m2_si = '{tf: m1_so.tf, tc: m1_so.tc, ap: m1_so.ap, ap5: m1_p[1], ap2: m1_p[0]};

   // lanes: a*a*P6, a*a*P3
   ptc_mul64 #(.LANES(2), .SIDE_W($bits(m2_side_type))) u_m2 (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_vld   (m1_vld),
      .in_x     ({m1_p[2], m1_p[2]}),
      .in_y     ({ptc_pkg::sx64(cal.p6), ptc_pkg::sx64(cal.p3)}),
      .in_side  (m2_si),
      .out_vld  (m2_vld),
      .out_p    (m2_p),
      .out_side (m2_so)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         r5_tf_ff <= m2_so.tf;
         r5_tc_ff <= m2_so.tc;
         r5_ap_ff <= m2_so.ap;
         r5_b_ff  <= m2_p[1] + (m2_so.ap5 << 17) + (ptc_pkg::sx64(cal.p4) << 35);
         r5_s_ff  <= ptc_pkg::ONE_Q47 + 64'($signed(m2_p[0]) >>> 8) + (m2_so.ap2 << 12);
      end
   end

   assign m3_si = '{tf: r5_tf_ff, tc: r5_tc_ff, ap: r5_ap_ff, b: r5_b_ff};

   ptc_mul64 #(.LANES(1), .SIDE_W($bits(m3_side_type))) u_m3 (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_vld   (r5_vld_ff),
      .in_x     (r5_s_ff),
      .in_y     ({48'd0, cal.p1}),
      .in_side  (m3_si),
      .out_vld  (m3_vld),
      .out_p    (m3_p),
      .out_side (m3_so)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         r6_tf_ff  <= m3_so.tf;
         r6_tc_ff  <= m3_so.tc;
         r6_den_ff <= 64'($signed(m3_p[0]) >>> 33);
         r6_x_ff   <= ((ptc_pkg::PRESS_FULL - 64'(m3_so.ap)) << 31) - m3_so.b;
      end
   end

   assign m4_si = '{tf: r6_tf_ff, tc: r6_tc_ff, den: r6_den_ff};

   ptc_mul64 #(.LANES(1), .SIDE_W($bits(m4_side_type))) u_m4 (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_vld   (r6_vld_ff),
      .in_x     (r6_x_ff),
      .in_y     (ptc_pkg::PRESS_SCALE),
      .in_side  (m4_si),
      .out_vld  (m4_vld),
      .out_p    (m4_p),
      .out_side (m4_so)
   );

   assign n = m4_p[0];

   // magnitudes for the unsigned divider, sign of the quotient kept aside
   always_ff @(posedge clock) begin
      if (en) begin
         r7_ff.rem <= '0;
         r7_ff.dq  <= n[63] ? -n : n;
         r7_ff.dvs <= m4_so.den[63] ? -m4_so.den : m4_so.den;
         r7_ff.neg <= n[63] ^ m4_so.den[63];
         r7_ff.dz  <= (m4_so.den == 64'd0);
         r7_ff.tf  <= m4_so.tf;
         r7_ff.tc  <= m4_so.tc;
      end
   end

   assign out_vld = r7_vld_ff;
   assign out_d   = r7_ff;

endmodule
`default_nettype wire

// ===== rtl/ptc_back.sv =====
`default_nettype none
// quotient sign, second-order terms and final scaling
module ptc_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  ptc_pkg::cal_type cal,
   input  logic             in_vld,
   input  ptc_pkg::div_type in_d,
   output logic             out_vld,
   output ptc_pkg::rsp_type out_r
);
   typedef struct packed {
      logic [31:0] tf;
      logic [31:0] tc;
      logic        dz;
      logic [63:0] p;
   } m5_side_type;

   typedef struct packed {
      logic [31:0] tf;
      logic [31:0] tc;
      logic        dz;
      logic [63:0] p;
      logic [63:0] e;
   } m6_side_type;

   logic        r8_vld_ff, r9_vld_ff, r10_vld_ff;
   logic [31:0] r8_tf_ff, r8_tc_ff, r9_tf_ff, r9_tc_ff;
   logic        r8_dz_ff, r9_dz_ff;
   logic [63:0] r8_p_ff, r9_sum_ff, ps, res;
   ptc_pkg::rsp_type r10_ff;

   logic             m5_vld, m6_vld;
   logic [1:0][63:0] m5_p;
   logic [0:0][63:0] m6_p;
   m5_side_type      m5_si, m5_so;
   m6_side_type      m6_si, m6_so;

   always_ff @(posedge clock) begin
      if (reset) begin
         r8_vld_ff  <= 1'b0;
         r9_vld_ff  <= 1'b0;
         r10_vld_ff <= 1'b0;
      end else if (en) begin
         r8_vld_ff  <= in_vld;
         r9_vld_ff  <= m6_vld;
         r10_vld_ff <= r9_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r8_p_ff  <= in_d.neg ? -in_d.dq : in_d.dq;
         r8_tf_ff <= in_d.tf;
         r8_tc_ff <= in_d.tc;
         r8_dz_ff <= in_d.dz;
      end
   end

   assign ps    = 64'($signed(r8_p_ff) >>> 13);
   assign m5_si = '{tf: r8_tf_ff, tc: r8_tc_ff, dz: r8_dz_ff, p: r8_p_ff};

   // lanes: ps*ps, P8*p
   ptc_mul64 #(.LANES(2), .SIDE_W($bits(m5_side_type))) u_m5 (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_vld   (r8_vld_ff),
      .in_x     ({ps, ptc_pkg::sx64(cal.p8)}),
      .in_y     ({ps, r8_p_ff}),
      .in_side  (m5_si),
      .out_vld  (m5_vld),
      .out_p    (m5_p),
      .out_side (m5_so)
   );

   assign m6_si = '{tf: m5_so.tf, tc: m5_so.tc, dz: m5_so.dz, p: m5_so.p,
                    e: 64'($signed(m5_p[0]) >>> 19)};

   ptc_mul64 #(.LANES(1), .SIDE_W($bits(m6_side_type))) u_m6 (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_vld   (m5_vld),
      .in_x     (m5_p[1]),
      .in_y     (ptc_pkg::sx64(cal.p9)),
      .in_side  (m6_si),
      .out_vld  (m6_vld),
      .out_p    (m6_p),
      .out_side (m6_so)
   );

   assign res = 64'($signed(r9_sum_ff) >>> 8) + (ptc_pkg::sx64(cal.p7) << 4);

   always_ff @(posedge clock) begin
      if (en) begin
         r9_sum_ff    <= m6_so.p + 64'($signed(m6_p[0]) >>> 25) + m6_so.e;
         r9_tf_ff     <= m6_so.tf;
         r9_tc_ff     <= m6_so.tc;
         r9_dz_ff     <= m6_so.dz;
         r10_ff.tf    <= r9_tf_ff;
         r10_ff.tc    <= r9_tc_ff;
         r10_ff.dz    <= r9_dz_ff;
         r10_ff.press <= r9_dz_ff ? 32'd0 : res[31:0];
      end
   end

   assign out_vld = r10_vld_ff;
   assign out_r   = r10_ff;

endmodule
`default_nettype wire

// ===== rtl/pressure_temperature_compensation.sv =====
`default_nettype none
// channel  | handshake                | payload
// request  | req_valid / req_stall    | req_adc_temp, req_adc_press
// response | rsp_valid / rsp_stall    | rsp_fine_temperature, rsp_temperature_centi,
//          |                          | rsp_pressure_q24_8, rsp_divide_by_zero
// csr      | psel, penable, pready    | paddr, pwdata, prdata (64-bit, regs at 8*i)
//
// One request per cycle while req_stall is low. Path: 15 front stages, 64 divider
// cells at one quotient bit each, 7 back stages and the output register.
// Synchronous reset clears valids and calibration registers to zero.
// A stalled response fills a one-entry skid; while it is full the pipeline
// freezes and req_stall is high.
module pressure_temperature_compensation (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [19:0]                 req_adc_temp,
   input  logic [19:0]                 req_adc_press,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic signed [31:0]          rsp_fine_temperature,
   output logic signed [31:0]          rsp_temperature_centi,
   output logic [31:0]                 rsp_pressure_q24_8,
   output logic                        rsp_divide_by_zero,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [ptc_pkg::ADDR_W-1:0]  paddr,
   input  logic [ptc_pkg::DATA_W-1:0]  pwdata,
   output logic [ptc_pkg::DATA_W-1:0]  prdata,
   output logic                        pready
);
   ptc_pkg::cal_type cal;
   logic             en;
   logic             chain_vld [ptc_pkg::DIV_STEPS+1];
   ptc_pkg::div_type chain_d   [ptc_pkg::DIV_STEPS+1];
   logic             tail_vld;
   ptc_pkg::rsp_type tail;

   logic             out_vld_ff, out_vld_in, skid_vld_ff, skid_vld_in, take;
   ptc_pkg::rsp_type out_ff, out_in, skid_ff, skid_in;

   assign en        = ~skid_vld_ff;
   assign req_stall = skid_vld_ff;

   ptc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cal     (cal)
   );

   ptc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .cal       (cal),
      .in_vld    (req_valid),
      .adc_temp  (req_adc_temp),
      .adc_press (req_adc_press),
      .out_vld   (chain_vld[0]),
      .out_d     (chain_d[0])
   );

   for (genvar i = 0; i < ptc_pkg::DIV_STEPS; i++) begin : g_div
      ptc_div_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .en      (en),
         .in_vld  (chain_vld[i]),
         .in_d    (chain_d[i]),
         .out_vld (chain_vld[i+1]),
         .out_d   (chain_d[i+1])
      );
   end

   ptc_back u_back (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .cal     (cal),
      .in_vld  (chain_vld[ptc_pkg::DIV_STEPS]),
      .in_d    (chain_d[ptc_pkg::DIV_STEPS]),
      .out_vld (tail_vld),
      .out_r   (tail)
   );

   assign take = out_vld_ff & ~rsp_stall;

   always_comb begin
      out_vld_in  = out_vld_ff;
      skid_vld_in = skid_vld_ff;
      out_in      = out_ff;
      skid_in     = skid_ff;
      if (skid_vld_ff) begin
         if (take) begin
            out_in      = skid_ff;
            skid_vld_in = 1'b0;
         end
      end else if (tail_vld) begin
         if (!out_vld_ff || take) begin
            out_in     = tail;
            out_vld_in = 1'b1;
         end else begin
            skid_in     = tail;
            skid_vld_in = 1'b1;
         end
      end else if (take) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         out_vld_ff  <= out_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid             = out_vld_ff;
   assign rsp_fine_temperature  = out_ff.tf;
   assign rsp_temperature_centi = out_ff.tc;
   assign rsp_pressure_q24_8    = out_ff.press;
   assign rsp_divide_by_zero    = out_ff.dz;

endmodule
`default_nettype wire
